// ===== rtl/esc_pkg.sv =====
// Shared types, constants and stage numbering for the sensor compensation pipeline.
package esc_pkg;

   localparam int DATA_W    = 64;
   localparam int CSR_IDX_W = 3;
   localparam int MUL_LAT   = 2;
   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_LAT   = DIV_STEPS + 2;

   // Stage numbers (stage 0 holds the accepted item)
   localparam int ST_TF      = 3;
   localparam int ST_V1      = 4;
   localparam int ST_HUM     = 11;
   localparam int ST_DIV_IN  = 12;
   localparam int ST_DIV_OUT = ST_DIV_IN + DIV_LAT;
   localparam int ST_LAST    = ST_DIV_OUT + 2 * MUL_LAT + 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_TEMP      = 3'd0,
      CSR_CAL_PRESS_A   = 3'd1,
      CSR_CAL_PRESS_B   = 3'd2,
      CSR_CAL_PRESS_HUM = 3'd3,
      CSR_CAL_HUM_B     = 3'd4
   } csr_index_type;

   localparam logic [63:0] P_T_OFFSET = 64'd128000;
   localparam logic [63:0] P_RAW_FULL = 64'd1048576;
   localparam logic [63:0] P_SCALE    = 64'd3125;
   localparam logic [63:0] P_BIAS47   = 64'h0000_8000_0000_0000;

   localparam logic [31:0] H_T_OFFSET = 32'd76800;
   localparam logic [31:0] H_ROUND_A  = 32'd16384;
   localparam logic [31:0] H_BIAS_A   = 32'd32768;
   localparam logic [31:0] H_BIAS_B   = 32'd2097152;
   localparam logic [31:0] H_ROUND_B  = 32'd8192;
   localparam logic [31:0] H_MAX      = 32'd419430400;

   typedef struct packed {
      logic [31:0] tf;
      logic [31:0] tc;
   } temp_type;

   typedef struct packed {
      logic [31:0] tf;
      logic [31:0] tc;
      logic [16:0] hum;
   } side_type;

endpackage

// ===== rtl/esc_mul64.sv =====
// Two-stage multiplier giving the low 64 bits of a 64 by 64 product from 32-bit partials.
module esc_mul64 (
   input  logic                       clock,
   input  logic                       adv,
   input  logic [esc_pkg::DATA_W-1:0] a,
   input  logic [esc_pkg::DATA_W-1:0] b,
   output logic [esc_pkg::DATA_W-1:0] p
);
   import esc_pkg::*;

   localparam int HW = DATA_W / 2;

   logic [DATA_W-1:0] ll_ff;
   logic [HW-1:0]     cross_ff;
   logic [DATA_W-1:0] p_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ll_ff    <= {{HW{1'b0}}, a[HW-1:0]} * {{HW{1'b0}}, b[HW-1:0]};
         cross_ff <= a[HW-1:0] * b[DATA_W-1:HW] + a[DATA_W-1:HW] * b[HW-1:0];
         p_ff     <= ll_ff + {cross_ff, {HW{1'b0}}};
      end
   end

   assign p = p_ff;

endmodule

// ===== rtl/esc_div.sv =====
// Pipelined signed 64-bit divider, one restoring step per stage, truncating toward zero.
module esc_div (
   input  logic                       clock,
   input  logic                       adv,
   input  logic [esc_pkg::DATA_W-1:0] num,
   input  logic [esc_pkg::DATA_W-1:0] den,
   output logic [esc_pkg::DATA_W-1:0] quo
);
   import esc_pkg::*;

   logic [DATA_W-1:0] rem_ff [0:DIV_STEPS];
   logic [DATA_W-1:0] dvd_ff [0:DIV_STEPS];
   logic [DATA_W-1:0] dvs_ff [0:DIV_STEPS];
   logic              neg_ff [0:DIV_STEPS];
   logic [DATA_W-1:0] quo_ff;

   // take magnitudes, keep the result sign
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= '0;
         dvd_ff[0] <= num[DATA_W-1] ? (~num + 1'b1) : num;
         dvs_ff[0] <= den[DATA_W-1] ? (~den + 1'b1) : den;
         neg_ff[0] <= num[DATA_W-1] ^ den[DATA_W-1];
      end
   end

   genvar i;
   for (i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [DATA_W-1:0] r2;
      logic              ge;
      assign r2 = {rem_ff[i][DATA_W-2:0], dvd_ff[i][DATA_W-1]};
      assign ge = (r2 >= dvs_ff[i]);
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i+1] <= ge ? (r2 - dvs_ff[i]) : r2;
            dvd_ff[i+1] <= {dvd_ff[i][DATA_W-2:0], ge};
            dvs_ff[i+1] <= dvs_ff[i];
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   // restore the sign
   always_ff @(posedge clock) begin
      if (adv) begin
         quo_ff <= neg_ff[DIV_STEPS] ? (~dvd_ff[DIV_STEPS] + 1'b1) : dvd_ff[DIV_STEPS];
      end
   end

   assign quo = quo_ff;

endmodule

// ===== rtl/env_sensor_compensation.sv =====
// Top level: pipelined integer compensation of temperature, pressure and humidity samples.
//
//  port group | dir | handshake            | payload
//  req_*      | in  | req_valid/req_stall  | raw_temp, raw_press, raw_hum
//  rsp_*      | out | rsp_valid/rsp_stall  | fine_temp, temp_centi, press_q24_8,
//             |     |                      | hum_q22_10, press_div_zero
//  csr_*      | in  | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One item enters per cycle while req_stall is low. Most of the path is the 64-step
// pressure divider; pipelined multipliers and adders sit before and after it.
// Reset clears the valid bits and the calibration registers.
// The whole pipeline holds in place while a shown result is stalled, so req_stall
// rises with it. The csr port never stalls.
module env_sensor_compensation (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [19:0]                   req_raw_temp,
   input  logic [19:0]                   req_raw_press,
   input  logic [15:0]                   req_raw_hum,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_fine_temp,
   output logic signed [31:0]            rsp_temp_centi,
   output logic [31:0]                   rsp_press_q24_8,
   output logic [16:0]                   rsp_hum_q22_10,
   output logic                          rsp_press_div_zero,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [esc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                   csr_wdata
);
   import esc_pkg::*;

   // ---------------------------------------------------------------- control
   logic               adv;
   logic [ST_LAST:0]   vld_ff;

   // advance everything unless the shown result is held
   assign adv       = !(vld_ff[ST_LAST] && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ST_LAST-1:0], req_valid};
      end
   end

   // ---------------------------------------------------------- calibration
   logic [47:0] cal_temp_ff;
   logic [63:0] cal_press_a_ff;
   logic [63:0] cal_press_b_ff;
   logic [47:0] cal_press_hum_ff;
   logic [31:0] cal_hum_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff      <= '0;
         cal_press_a_ff   <= '0;
         cal_press_b_ff   <= '0;
         cal_press_hum_ff <= '0;
         cal_hum_b_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAL_TEMP:      cal_temp_ff      <= csr_wdata[47:0];
            CSR_CAL_PRESS_A:   cal_press_a_ff   <= csr_wdata;
            CSR_CAL_PRESS_B:   cal_press_b_ff   <= csr_wdata;
            CSR_CAL_PRESS_HUM: cal_press_hum_ff <= csr_wdata[47:0];
            CSR_CAL_HUM_B:     cal_hum_b_ff     <= csr_wdata[31:0];
            default: ;   // drop writes past the register list
         endcase
      end
   end

   // unpack coefficients, extended to the width each formula works in
   logic [31:0] t1_w, t2_w, t3_w;
   logic [63:0] p1_w, p2_w, p3_w, p4_w, p5_w, p6_w, p7_w, p8_w, p9_w;
   logic [31:0] h1_w, h2_w, h3_w, h4_w, h5_w, h6_w;

   assign t1_w = {16'd0, cal_temp_ff[15:0]};
   assign t2_w = {{16{cal_temp_ff[31]}}, cal_temp_ff[31:16]};
   assign t3_w = {{16{cal_temp_ff[47]}}, cal_temp_ff[47:32]};
   assign p1_w = {48'd0, cal_press_a_ff[15:0]};
   assign p2_w = {{48{cal_press_a_ff[31]}}, cal_press_a_ff[31:16]};
   assign p3_w = {{48{cal_press_a_ff[47]}}, cal_press_a_ff[47:32]};
   assign p4_w = {{48{cal_press_a_ff[63]}}, cal_press_a_ff[63:48]};
   assign p5_w = {{48{cal_press_b_ff[15]}}, cal_press_b_ff[15:0]};
   assign p6_w = {{48{cal_press_b_ff[31]}}, cal_press_b_ff[31:16]};
   assign p7_w = {{48{cal_press_b_ff[47]}}, cal_press_b_ff[47:32]};
   assign p8_w = {{48{cal_press_b_ff[63]}}, cal_press_b_ff[63:48]};
   assign p9_w = {{48{cal_press_hum_ff[15]}}, cal_press_hum_ff[15:0]};
   assign h1_w = {24'd0, cal_press_hum_ff[23:16]};
   assign h2_w = {{16{cal_press_hum_ff[39]}}, cal_press_hum_ff[39:24]};
   assign h3_w = {24'd0, cal_press_hum_ff[47:40]};
   assign h4_w = {{20{cal_hum_b_ff[11]}}, cal_hum_b_ff[11:0]};
   assign h5_w = {{20{cal_hum_b_ff[23]}}, cal_hum_b_ff[23:12]};
   assign h6_w = {{24{cal_hum_b_ff[31]}}, cal_hum_b_ff[31:24]};

   // ------------------------------------------------------- input capture
   logic [19:0] rt_ff;
   logic [19:0] rp_ff [0:9];
   logic [15:0] rh_ff [0:ST_V1];

   always_ff @(posedge clock) begin
      if (adv) begin
         rt_ff    <= req_raw_temp;
         rp_ff[0] <= req_raw_press;
         rh_ff[0] <= req_raw_hum;
         for (int k = 1; k <= 9; k++) begin
            rp_ff[k] <= rp_ff[k-1];
         end
         for (int k = 1; k <= ST_V1; k++) begin
            rh_ff[k] <= rh_ff[k-1];
         end
      end
   end

   // --------------------------------------------------------- temperature
   // stage 1: both products; stage 2: second product with T3; stage 3: sum
   logic [31:0] ta_in, td_in;
   logic [31:0] ma_ff, mdd_ff, aa_ff, mb_ff, tf_ff;

   assign ta_in = {15'd0, rt_ff[19:3]} - {15'd0, t1_w[15:0], 1'b0};
   assign td_in = {16'd0, rt_ff[19:4]} - t1_w;

   always_ff @(posedge clock) begin
      if (adv) begin
         ma_ff  <= ta_in * t2_w;
         mdd_ff <= td_in * td_in;
         aa_ff  <= 32'($signed(ma_ff) >>> 11);
         mb_ff  <= 32'($signed(mdd_ff) >>> 12) * t3_w;
         tf_ff  <= aa_ff + 32'($signed(mb_ff) >>> 14);
      end
   end

   // stage 4: centi-degrees, pressure and humidity offsets
   logic [31:0] tc_in;
   temp_type    tt_ff [ST_V1:ST_HUM];
   logic [63:0] v1_ff;
   logic [31:0] hx_ff;

   assign tc_in = 32'($signed(tf_ff * 32'd5 + 32'd128) >>> 8);

   always_ff @(posedge clock) begin
      if (adv) begin
         tt_ff[ST_V1] <= '{tf: tf_ff, tc: tc_in};
         for (int k = ST_V1 + 1; k <= ST_HUM; k++) begin
            tt_ff[k] <= tt_ff[k-1];
         end
         v1_ff <= {{32{tf_ff[31]}}, tf_ff} - P_T_OFFSET;
         hx_ff <= tf_ff - H_T_OFFSET;
      end
   end

   // ------------------------------------------------------------ humidity
   // one multiplier level per stage in stages 5 to 10, clamp in stage 11
   logic [31:0] hbase_in, hm4_in, hm5_in, hs_in, hr_in;
   logic [16:0] hum_in;
   logic [31:0] hm1_ff, hm2_ff, hm3_ff, hbase_ff;
   logic [31:0] hw1_ff, hm4_ff, hw1b_ff, hm5_ff;
   logic [31:0] hx6_ff, hx6b_ff, hx6c_ff, hm7_ff, hm8_ff;
   logic [16:0] hum_ff;

   always_comb begin
      hbase_in = {2'd0, rh_ff[ST_V1], 14'd0} - {h4_w[11:0], 20'd0} + H_ROUND_A;
      hm4_in   = 32'($signed(hm3_ff) >>> 11) + H_BIAS_A;
      hm5_in   = 32'($signed(hm4_ff) >>> 10) + H_BIAS_B;
      hs_in    = 32'($signed(hx6_ff) >>> 15);
      hr_in    = hx6c_ff - 32'($signed(hm8_ff) >>> 4);
      // clamp to 0..100 percent
      if (hr_in[31]) begin
         hum_in = '0;
      end else if (hr_in > H_MAX) begin
         hum_in = H_MAX[28:12];
      end else begin
         hum_in = hr_in[28:12];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hm1_ff   <= h5_w * hx_ff;
         hm2_ff   <= hx_ff * h6_w;
         hm3_ff   <= hx_ff * h3_w;
         hbase_ff <= hbase_in;
         hw1_ff   <= 32'($signed(hbase_ff - hm1_ff) >>> 15);
         hm4_ff   <= 32'($signed(hm2_ff) >>> 10) * hm4_in;
         hw1b_ff  <= hw1_ff;
         hm5_ff   <= hm5_in * h2_w + H_ROUND_B;
         hx6_ff   <= hw1b_ff * 32'($signed(hm5_ff) >>> 14);
         hm7_ff   <= hs_in * hs_in;
         hx6b_ff  <= hx6_ff;
         hm8_ff   <= 32'($signed(hm7_ff) >>> 7) * h1_w;
         hx6c_ff  <= hx6b_ff;
         hum_ff   <= hum_in;
      end
   end

   // ------------------------------------------------- pressure, divisor side
   logic [63:0] vv_w, v1p5_w, v1p2_w, vvp6_w, vvp3_w, den_pre_w, num_w;
   logic [63:0] v1p5_ff [1:MUL_LAT];
   logic [63:0] v1p2_ff [1:MUL_LAT];
   logic [63:0] v2_ff, u_ff, nb_ff, den_ff;
   logic [63:0] praw_in, den_in;

   esc_mul64 u_mul_vv   (.clock, .adv, .a(v1_ff), .b(v1_ff), .p(vv_w));
   esc_mul64 u_mul_v1p5 (.clock, .adv, .a(v1_ff), .b(p5_w),  .p(v1p5_w));
   esc_mul64 u_mul_v1p2 (.clock, .adv, .a(v1_ff), .b(p2_w),  .p(v1p2_w));
   esc_mul64 u_mul_vvp6 (.clock, .adv, .a(vv_w),  .b(p6_w),  .p(vvp6_w));
   esc_mul64 u_mul_vvp3 (.clock, .adv, .a(vv_w),  .b(p3_w),  .p(vvp3_w));
   esc_mul64 u_mul_den  (.clock, .adv, .a(u_ff),  .b(p1_w),  .p(den_pre_w));
   esc_mul64 u_mul_num  (.clock, .adv, .a(nb_ff), .b(P_SCALE), .p(num_w));

   assign praw_in = P_RAW_FULL - {44'd0, rp_ff[9]};
   assign den_in  = 64'($signed(den_pre_w) >>> 33);

   always_ff @(posedge clock) begin
      if (adv) begin
         v1p5_ff[1] <= v1p5_w;
         v1p2_ff[1] <= v1p2_w;
         for (int k = 2; k <= MUL_LAT; k++) begin
            v1p5_ff[k] <= v1p5_ff[k-1];
            v1p2_ff[k] <= v1p2_ff[k-1];
         end
         v2_ff  <= vvp6_w + {v1p5_ff[MUL_LAT][46:0], 17'd0} + {p4_w[28:0], 35'd0};
         u_ff   <= 64'($signed(vvp3_w) >>> 8) + {v1p2_ff[MUL_LAT][51:0], 12'd0} + P_BIAS47;
         nb_ff  <= {praw_in[32:0], 31'd0} - v2_ff;
         den_ff <= den_in;
      end
   end

   // ------------------------------------------------------------ division
   logic [63:0] p_w;

   esc_div u_div (.clock, .adv, .num(num_w), .den(den_ff), .quo(p_w));

   // carry the zero-divisor flag and the side results past the divider
   logic     dz_ff   [ST_DIV_IN:ST_LAST];
   side_type side_ff [ST_DIV_IN:ST_LAST];

   always_ff @(posedge clock) begin
      if (adv) begin
         dz_ff[ST_DIV_IN]   <= (den_in == '0);
         side_ff[ST_DIV_IN] <= '{tf: tt_ff[ST_HUM].tf, tc: tt_ff[ST_HUM].tc, hum: hum_ff};
         for (int k = ST_DIV_IN + 1; k <= ST_LAST; k++) begin
            dz_ff[k]   <= dz_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // --------------------------------------------------- pressure correction
   localparam int SQ = ST_DIV_OUT;

   logic [63:0] pq_w, p8p_w, e1_w;
   logic [63:0] pd_ff [SQ+1:SQ+2*MUL_LAT];
   logic [63:0] e2_ff [SQ+MUL_LAT+1:SQ+2*MUL_LAT];
   logic [63:0] sum_ff;
   logic [63:0] press_in;
   logic [31:0] press_ff;

   esc_mul64 u_mul_pq  (.clock, .adv, .a(p9_w), .b(64'($signed(p_w) >>> 13)), .p(pq_w));
   esc_mul64 u_mul_p8p (.clock, .adv, .a(p8_w), .b(p_w), .p(p8p_w));
   esc_mul64 u_mul_e1  (.clock, .adv, .a(pq_w),
                        .b(64'($signed(pd_ff[SQ+MUL_LAT]) >>> 13)), .p(e1_w));

   assign press_in = 64'($signed(sum_ff) >>> 8) + {p7_w[59:0], 4'd0};

   always_ff @(posedge clock) begin
      if (adv) begin
         pd_ff[SQ+1] <= p_w;
         for (int k = SQ + 2; k <= SQ + 2 * MUL_LAT; k++) begin
            pd_ff[k] <= pd_ff[k-1];
         end
         e2_ff[SQ+MUL_LAT+1] <= 64'($signed(p8p_w) >>> 19);
         for (int k = SQ + MUL_LAT + 2; k <= SQ + 2 * MUL_LAT; k++) begin
            e2_ff[k] <= e2_ff[k-1];
         end
         sum_ff   <= pd_ff[SQ+2*MUL_LAT] + 64'($signed(e1_w) >>> 25)
                     + e2_ff[SQ+2*MUL_LAT];
         // force zero when the divisor was zero
         press_ff <= dz_ff[ST_LAST-1] ? 32'd0 : press_in[31:0];
      end
   end

   // -------------------------------------------------------------- outputs
   assign rsp_valid          = vld_ff[ST_LAST];
   assign rsp_fine_temp      = side_ff[ST_LAST].tf;
   assign rsp_temp_centi     = side_ff[ST_LAST].tc;
   assign rsp_hum_q22_10     = side_ff[ST_LAST].hum;
   assign rsp_press_q24_8    = press_ff;
   assign rsp_press_div_zero = dz_ff[ST_LAST];

endmodule

// ===== rtl/esc_checker.sv =====
// Port-level checker for the compensation block, bound to the top level.
module esc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_fine_temp,
   input logic signed [31:0] rsp_temp_centi,
   input logic [31:0]        rsp_press_q24_8,
   input logic [16:0]        rsp_hum_q22_10,
   input logic               rsp_press_div_zero
);
   logic [31:0] tc_chk;

   assign tc_chk = 32'($signed(rsp_fine_temp * 32'sd5 + 32'sd128) >>> 8);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fine_temp)
         && $stable(rsp_press_q24_8) && $stable(rsp_hum_q22_10))
      else $error("held item changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output held");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hum_q22_10 <= 17'd102400)
      else $error("humidity above clamp");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_press_div_zero |-> rsp_press_q24_8 == 32'd0)
      else $error("pressure not zero on zero divisor");

   a_centi: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temp_centi == tc_chk)
      else $error("temperature out of step with fine term");

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (.*);

// ===== tb/tb_env_sensor_compensation.sv =====
// Testbench for env_sensor_compensation: compensated outputs checked against a local predictor.
`timescale 1ns / 100ps

module tb_env_sensor_compensation;
   import esc_pkg::*;

   localparam int LATENCY = 84;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [19:0] req_raw_temp = '0;
   logic [19:0] req_raw_press = '0;
   logic [15:0] req_raw_hum = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [31:0] rsp_fine_temp;
   logic signed [31:0] rsp_temp_centi;
   logic [31:0] rsp_press_q24_8;
   logic [16:0] rsp_hum_q22_10;
   logic        rsp_press_div_zero;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   env_sensor_compensation dut (.*);

   typedef struct {
      logic [31:0] fine;
      logic [31:0] centi;
      logic [31:0] press;
      logic [16:0] hum;
      logic        dz;
   } comp_result_type;

   // local copy of the calibration registers
   logic [47:0] cal_t, cal_ph;
   logic [63:0] cal_pa, cal_pb;
   logic [31:0] cal_hb;

   comp_result_type expected_q[$];
   int  errors = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   longint cycles = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Watchdog: count cycles, end the run if the limit is hit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_env_sensor_compensation: done, errors");
         $finish;
      end
   end

   // Compute one sample the way the published integer formulas do.
   function automatic comp_result_type compensate(logic [19:0] adc_t, logic [19:0] adc_p,
                                                  logic [15:0] adc_h);
      comp_result_type r;
      logic signed [31:0] t1, t2, t3, a, d, b, tf, x, w1, w2, s, hx;
      logic signed [31:0] h1, h2, h3, h4, h5, h6;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] v1, v2, p, q, e1, e2, num, press;
      logic [63:0] ma, mb, uq;
      t1 = {16'd0, cal_t[15:0]};
      t2 = {{16{cal_t[31]}}, cal_t[31:16]};
      t3 = {{16{cal_t[47]}}, cal_t[47:32]};
      a  = ($signed({12'd0, adc_t} >>> 3) - (t1 << 1)) * t2 >>> 11;
      d  = ({12'd0, adc_t} >>> 4) - t1;
      b  = (((d * d) >>> 12) * t3) >>> 14;
      tf = a + b;
      r.fine  = tf;
      r.centi = (tf * 5 + 128) >>> 8;

      p1 = {48'd0, cal_pa[15:0]};
      p2 = {{48{cal_pa[31]}}, cal_pa[31:16]};
      p3 = {{48{cal_pa[47]}}, cal_pa[47:32]};
      p4 = {{48{cal_pa[63]}}, cal_pa[63:48]};
      p5 = {{48{cal_pb[15]}}, cal_pb[15:0]};
      p6 = {{48{cal_pb[31]}}, cal_pb[31:16]};
      p7 = {{48{cal_pb[47]}}, cal_pb[47:32]};
      p8 = {{48{cal_pb[63]}}, cal_pb[63:48]};
      p9 = {{48{cal_ph[15]}}, cal_ph[15:0]};
      v1 = 64'(tf) - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
      v1 = (((64'sd1 << 47) + v1) * p1) >>> 33;
      press = 0;
      r.dz = (v1 == 0);
      if (!r.dz) begin
         p   = 64'sd1048576 - {44'd0, adc_p};
         num = ((p << 31) - v2) * 64'sd3125;
         // signed divide by magnitudes so min / -1 wraps like two's complement
         ma = num[63] ? -num : num;
         mb = v1[63] ? -v1 : v1;
         uq = ma / mb;
         p  = (num[63] != v1[63]) ? -uq : uq;
         q  = p >>> 13;
         e1 = (p9 * q * q) >>> 25;
         e2 = (p8 * p) >>> 19;
         press = ((p + e1 + e2) >>> 8) + (p7 << 4);
      end
      r.press = press[31:0];

      h1 = {24'd0, cal_ph[23:16]};
      h2 = {{16{cal_ph[39]}}, cal_ph[39:24]};
      h3 = {24'd0, cal_ph[47:40]};
      h4 = {{20{cal_hb[11]}}, cal_hb[11:0]};
      h5 = {{20{cal_hb[23]}}, cal_hb[23:12]};
      h6 = {{24{cal_hb[31]}}, cal_hb[31:24]};
      x  = tf - 32'sd76800;
      w1 = ($signed({16'd0, adc_h} << 14) - (h4 << 20) - h5 * x + 32'sd16384) >>> 15;
      w2 = (((((x * h6) >>> 10) * (((x * h3) >>> 11) + 32'sd32768)) >>> 10)
            + 32'sd2097152) * h2 + 32'sd8192;
      w2 = w2 >>> 14;
      hx = w1 * w2;
      s  = hx >>> 15;
      hx = hx - ((((s * s) >>> 7) * h1) >>> 4);
      if (hx < 0)
         hx = 0;
      else if (hx > 32'sd419430400)
         hx = 32'sd419430400;
      r.hum = hx[28:12];
      return r;
   endfunction

   // Write one calibration register; mirror it locally when the index exists.
   task automatic write_cal(csr_index_type idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CAL_TEMP:      cal_t  = value[47:0];
         CSR_CAL_PRESS_A:   cal_pa = value;
         CSR_CAL_PRESS_B:   cal_pb = value;
         CSR_CAL_PRESS_HUM: cal_ph = value[47:0];
         CSR_CAL_HUM_B:     cal_hb = value[31:0];
         default: ;
      endcase
   endtask

   // Load all five registers in one idle window.
   task automatic load_cal(logic [63:0] t, logic [63:0] pa, logic [63:0] pb,
                           logic [63:0] ph, logic [63:0] hb);
      write_cal(CSR_CAL_TEMP, t);
      write_cal(CSR_CAL_PRESS_A, pa);
      write_cal(CSR_CAL_PRESS_B, pb);
      write_cal(CSR_CAL_PRESS_HUM, ph);
      write_cal(CSR_CAL_HUM_B, hb);
   endtask

   // Send one sample; hold valid and payload until accepted, and queue its prediction.
   task automatic send_sample(logic [19:0] t, logic [19:0] p, logic [15:0] h);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_raw_temp  <= t;
      req_raw_press <= p;
      req_raw_hum   <= h;
      expected_q.push_back(compensate(t, p, h));
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until the pipeline has drained.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Random stall on the result side.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      comp_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result fine=%h", $realtime, rsp_fine_temp);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_fine_temp !== e.fine) begin
               $display("%0t: fine_temp exp %h got %h", $realtime, e.fine, rsp_fine_temp);
               errors++;
            end
            if (rsp_temp_centi !== e.centi) begin
               $display("%0t: temp_centi exp %h got %h", $realtime, e.centi, rsp_temp_centi);
               errors++;
            end
            if (rsp_press_q24_8 !== e.press) begin
               $display("%0t: press exp %h got %h", $realtime, e.press, rsp_press_q24_8);
               errors++;
            end
            if (rsp_hum_q22_10 !== e.hum) begin
               $display("%0t: hum exp %h got %h", $realtime, e.hum, rsp_hum_q22_10);
               errors++;
            end
            if (rsp_press_div_zero !== e.dz) begin
               $display("%0t: div_zero exp %b got %b", $realtime, e.dz, rsp_press_div_zero);
               errors++;
            end
         end
      end
   end

   // Random calibration word, and a fixed typical calibration set.
   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   task automatic load_typical();
      load_cal(64'({16'sd50, 16'sd26435, 16'd27504}),
               {16'sd2855, 16'sd8240 - 16'sd2, -16'sd10685, 16'd36477},
               {-16'sd12000, -16'sd7, 16'sd140, -16'sd7},
               64'({8'd0, 16'sd361, 8'd75, 16'sd6000}),
               64'({8'sd30, 12'sd50, 12'sd312}));
   endtask

   // Reset defaults: all zero, so the pressure divisor is zero.
   task automatic test_reset_values();
      send_sample(20'h0, 20'h0, 16'h0);
      send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      drain();
   endtask

   // Extremes, humidity clamps on realistic cal, then zero divisor, extreme cal, bad index.
   task automatic test_directed();
      load_typical();
      send_sample(20'd519888, 20'd415148, 16'd27000);
      send_sample(20'h0, 20'h0, 16'h0);
      send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send_sample(20'h80000, 20'h80000, 16'h8000);
      send_sample(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
      send_sample(20'd519888, 20'd415148, 16'h0);    // humidity clamps low
      send_sample(20'd519888, 20'd415148, 16'hFFFF); // humidity clamps high
      drain();
      // zero P1 forces a zero divisor with the rest intact
      write_cal(CSR_CAL_PRESS_A, {cal_pa[63:16], 16'd0});
      send_sample(20'd519888, 20'd415148, 16'd27000);
      drain();
      // all-ones and extreme signed coefficients: wrap and most-negative cases
      load_cal('1, '1, '1, '1, '1);
      send_sample(20'hFFFFF, 20'h0, 16'hFFFF);
      send_sample(20'h0, 20'hFFFFF, 16'h0);
      drain();
      load_cal(64'({16'h8000, 16'h8000, 16'hFFFF}),
               {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
               {16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF},
               64'({8'hFF, 16'h8000, 8'hFF, 16'h8000}),
               64'({8'h80, 12'h800, 12'h800}));
      send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send_sample(20'h0, 20'h0, 16'h0);
      drain();
      // index beyond the register list must be ignored
      write_cal(csr_index_type'(3'd7), '1);
      write_cal(csr_index_type'(3'd5), '1);
      send_sample(20'h12345, 20'h54321, 16'h1234);
      drain();
   endtask

   // Random samples in one idling phase; mostly realistic calibration, some random.
   task automatic test_random(int n, int idle, int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      if ($urandom_range(3) == 0)
         load_cal(rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
      else
         load_typical();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(1))
            send_sample(20'($urandom_range(600000, 400000)),
                        20'($urandom_range(500000, 200000)), 16'($urandom));
         else
            send_sample(20'($urandom), 20'($urandom), 16'($urandom));
      end
      drain();
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      cal_t = '0; cal_pa = '0; cal_pb = '0; cal_ph = '0; cal_hb = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed();
      // cycle through idling phases, new calibration each time
      for (int k = 0; k < 2; k++) begin
         test_random(140, 0, 0);
         test_random(140, 47, 0);
         test_random(140, 0, 47);
         test_random(130, 9, 9);
      end
      if (errors == 0 && expected_q.size() == 0)
         $display("tb_env_sensor_compensation: done, clean");
      else
         $display("tb_env_sensor_compensation: done, errors");
      $finish;
   end

endmodule
